>>> rtl/core/owm_pkg.sv
// Shared types and constants for the one-wire bus master.
// Used by the channel interfaces, the core and the top level; no dependencies.
package owm_pkg;

	localparam int TIMER_BITS = 10;
	localparam int TIMER_MAX  = (1 << TIMER_BITS) - 1;
	localparam int CFG_W      = 10;
	localparam int N_CFG      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int MODE_W     = 2;
	localparam int BYTE_W     = 8;
	localparam int BIT_CNT_W  = 4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRE_RELEASE,
		CFG_RESET_LOW,
		CFG_PRESENCE_DELAY,
		CFG_PRESENCE_TIMEOUT,
		CFG_RECOVERY,
		CFG_SLOT_START,
		CFG_SLOT_HOLD,
		CFG_BIT_GAP
	} cfg_idx_t;

	// Command codes carried in the mode field
	typedef enum logic [MODE_W-1:0] {
		MODE_TICK,
		MODE_RESET,
		MODE_WRITE,
		MODE_READ
	} mode_t;

	typedef logic [N_CFG-1:0][CFG_W-1:0] cfg_regs_t;

	// Register values after reset, highest index first
	localparam cfg_regs_t CFG_RESET = {
		10'd2, 10'd65, 10'd5, 10'd500, 10'd500, 10'd40, 10'd500, 10'd50
	};

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] data_byte;
		logic              line_level;
	} item_t;

	typedef struct packed {
		logic              drive_low;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] read_data;
		logic              no_presence;
		logic              rejected;
	} result_t;

endpackage

>>> rtl/core/owm_channels.sv
// Valid/ready channel interfaces for command input and result output.
// Depends on owm_pkg for field widths.
interface owm_in_if;
	import owm_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [BYTE_W-1:0] data_byte;
	logic              line_level;

	modport source(output valid, mode, data_byte, line_level, input ready);
	modport sink(input valid, mode, data_byte, line_level, output ready);
endinterface

interface owm_out_if;
	import owm_pkg::*;

	logic              valid;
	logic              ready;
	logic              drive_low;
	logic              busy_res;
	logic              done_res;
	logic [BYTE_W-1:0] read_data;
	logic              no_presence;
	logic              rejected;

	modport source(output valid, drive_low, busy_res, done_res, read_data, no_presence,
		rejected, input ready);
	modport sink(input valid, drive_low, busy_res, done_res, read_data, no_presence,
		rejected, output ready);
endinterface

>>> rtl/core/owm_core.sv
// Bus sequencer: phase state, slot timer, bit shifter and next-state logic.
// Depends on owm_pkg.
module owm_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  owm_pkg::item_t     item,
	input  owm_pkg::cfg_regs_t cfg,
	output owm_pkg::result_t   result
);
	import owm_pkg::*;

	// Zero-length phases are skipped within one step; this bounds the chain
	localparam int WALK_STEPS = 6;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_R_PRE, PH_R_LOW, PH_R_DELAY, PH_R_POLL, PH_R_RECOV,
		PH_W_LOW, PH_W_HOLD, PH_W_GAP,
		PH_RD_PRE, PH_RD_LOW, PH_RD_REL, PH_RD_HOLD
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic [TIMER_BITS-1:0]  timer;
		logic [BIT_CNT_W-1:0]   bits;
		logic [BYTE_W-1:0]      shift;
		logic [BYTE_W-1:0]      recv;
		logic                   absent;
	} st_t;

	typedef struct packed {
		st_t  st;
		logic done;
	} step_t;

	st_t   st_q;
	st_t   entry;
	step_t nx;
	logic  do_enter;
	logic  rej;
	logic [TIMER_BITS-1:0] tick_next;

	// Slot length of a phase, saturated to the timer range
	function automatic logic [TIMER_BITS-1:0] phase_len(phase_t p, cfg_regs_t c);
		logic [CFG_W-1:0] v;
		case (p) inside
			PH_R_PRE:   v = c[CFG_PRE_RELEASE];
			PH_R_LOW:   v = c[CFG_RESET_LOW];
			PH_R_DELAY: v = c[CFG_PRESENCE_DELAY];
			PH_R_POLL:  v = c[CFG_PRESENCE_TIMEOUT];
			PH_R_RECOV: v = c[CFG_RECOVERY];
			PH_W_LOW, PH_RD_PRE, PH_RD_LOW, PH_RD_REL: v = c[CFG_SLOT_START];
			PH_W_HOLD, PH_RD_HOLD: v = c[CFG_SLOT_HOLD];
			PH_W_GAP:   v = c[CFG_BIT_GAP];
			default:    v = '0;
		endcase
		if (32'(v) > TIMER_MAX)
			return TIMER_BITS'(TIMER_MAX);
		return TIMER_BITS'(v);
	endfunction

	function automatic logic [BIT_CNT_W-1:0] dec_bits(logic [BIT_CNT_W-1:0] b);
		return (b != '0) ? b - BIT_CNT_W'(1) : '0;
	endfunction

	// End-of-phase actions; the returned phase field is the next phase
	function automatic st_t finish(st_t s, logic level);
		st_t r;
		r = s;
		case (s.phase)
			PH_R_PRE:   r.phase = PH_R_LOW;
			PH_R_LOW:   r.phase = PH_R_DELAY;
			PH_R_DELAY: r.phase = PH_R_POLL;
			PH_R_POLL: begin
				r.absent = 1'b1;
				r.phase  = PH_R_RECOV;
			end
			PH_W_LOW:   r.phase = PH_W_HOLD;
			PH_W_HOLD:  r.phase = PH_W_GAP;
			PH_W_GAP: begin
				r.shift = s.shift >> 1;
				r.bits  = dec_bits(s.bits);
				r.phase = (r.bits != '0) ? PH_W_LOW : PH_IDLE;
			end
			PH_RD_PRE:  r.phase = PH_RD_LOW;
			PH_RD_LOW:  r.phase = PH_RD_REL;
			PH_RD_REL: begin
				r.shift = {level, s.shift[BYTE_W-1:1]};
				r.bits  = dec_bits(s.bits);
				r.phase = PH_RD_HOLD;
			end
			PH_RD_HOLD: begin
				if (s.bits == '0) begin
					r.recv  = s.shift;
					r.phase = PH_IDLE;
				end else begin
					r.phase = PH_RD_LOW;
				end
			end
			default:    r.phase = PH_IDLE;
		endcase
		return r;
	endfunction

	// Enter s.phase, passing through phases of zero length
	function automatic step_t walk(st_t s, logic level, cfg_regs_t c);
		step_t                 r;
		logic                  stop;
		logic [TIMER_BITS-1:0] len;
		logic                  z_start;
		logic                  z_hold;
		logic                  z_gap;
		logic [BYTE_W-1:0]     fill;
		r.st    = s;
		r.done  = 1'b0;
		stop    = 1'b0;
		z_start = (phase_len(PH_W_LOW, c) == '0);
		z_hold  = (phase_len(PH_W_HOLD, c) == '0);
		z_gap   = (phase_len(PH_W_GAP, c) == '0);
		fill    = level ? ~({BYTE_W{1'b1}} >> s.bits) : '0;
		// all-zero slots: every remaining bit goes by in this step
		if ((s.phase == PH_W_LOW || s.phase == PH_W_HOLD || s.phase == PH_W_GAP) &&
				z_start && z_hold && z_gap) begin
			r.st.shift = s.shift >> s.bits;
			r.st.bits  = '0;
			r.st.phase = PH_IDLE;
		end else if ((s.phase == PH_RD_PRE || s.phase == PH_RD_LOW ||
				s.phase == PH_RD_REL || s.phase == PH_RD_HOLD) && z_start && z_hold) begin
			r.st.shift = (s.shift >> s.bits) | fill;
			r.st.recv  = (s.shift >> s.bits) | fill;
			r.st.bits  = '0;
			r.st.phase = PH_IDLE;
		end
		for (int i = 0; i < WALK_STEPS; i++) begin
			if (!stop) begin
				if (r.st.phase == PH_IDLE) begin
					r.st.timer = '0;
					r.done     = 1'b1;
					stop       = 1'b1;
				end else begin
					len = phase_len(r.st.phase, c);
					if (len != '0) begin
						r.st.timer = len;
						stop       = 1'b1;
					end else begin
						r.st = finish(r.st, level);
					end
				end
			end
		end
		return r;
	endfunction

	// Command start or one tick of the running phase
	always_comb begin
		entry     = st_q;
		do_enter  = 1'b0;
		rej       = 1'b0;
		tick_next = (st_q.timer != '0) ? st_q.timer - TIMER_BITS'(1) : '0;
		if (item.mode != MODE_TICK) begin
			if (st_q.phase != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				case (item.mode)
					MODE_RESET: begin
						entry.phase = PH_R_PRE;
						do_enter    = 1'b1;
					end
					MODE_WRITE: begin
						entry.shift = item.data_byte;
						entry.bits  = BIT_CNT_W'(BYTE_W);
						entry.phase = PH_W_LOW;
						do_enter    = 1'b1;
					end
					MODE_READ: begin
						entry.bits  = BIT_CNT_W'(BYTE_W);
						entry.phase = PH_RD_PRE;
						do_enter    = 1'b1;
					end
					default: ;
				endcase
			end
		end else if (st_q.phase != PH_IDLE) begin
			if (st_q.phase == PH_R_POLL && !item.line_level) begin
				// presence seen
				entry.absent = 1'b0;
				entry.phase  = PH_R_RECOV;
				do_enter     = 1'b1;
			end else if (tick_next == '0) begin
				entry.timer = '0;
				entry       = finish(entry, item.line_level);
				do_enter    = 1'b1;
			end else begin
				entry.timer = tick_next;
			end
		end
		if (do_enter) begin
			nx = walk(entry, item.line_level, cfg);
		end else begin
			nx.st   = entry;
			nx.done = 1'b0;
		end
	end

	// Result fields from the state after this step
	always_comb begin
		case (nx.st.phase)
			PH_R_LOW, PH_W_LOW, PH_RD_LOW: result.drive_low = 1'b1;
			PH_W_HOLD:                     result.drive_low = ~nx.st.shift[0];
			default:                       result.drive_low = 1'b0;
		endcase
		result.busy_res    = (nx.st.phase != PH_IDLE);
		result.done_res    = nx.done;
		result.read_data   = nx.st.recv;
		result.no_presence = nx.st.absent;
		result.rejected    = rej;
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase  <= PH_IDLE;
			st_q.timer  <= '0;
			st_q.bits   <= '0;
			st_q.shift  <= '0;
			st_q.recv   <= '0;
			st_q.absent <= 1'b0;
		end else if (fire) begin
			st_q <= nx.st;
		end
	end

endmodule

>>> rtl/core/one_wire_bus_master.sv
// One-wire bus master: one tick or command per input transfer, one result per transfer.
// Path: each item passes the input register, then the core, then the result register before its result is offered.
// Throughput: one item per cycle; a waiting result lets one more item in, then stalls input.
// Timing of the bus slots is counted in input ticks by the slot timer in owm_core.
// Reset: arst_n clears control state, sequencer state and loads the register defaults.
// Depends on owm_pkg, owm_channels and owm_core.
module one_wire_bus_master (
	input  logic                            clk,
	input  logic                            arst_n,
	owm_in_if.sink                          in_ch,
	owm_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [owm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [owm_pkg::CFG_W-1:0]       cfg_data
);
	import owm_pkg::*;

	cfg_regs_t cfg_q;
	item_t     item_s1;
	logic      valid_s1;
	result_t   res_q;
	logic      out_valid_q;
	result_t   core_res;
	logic      advance;
	logic      fire;
	logic      in_xfer;

	// Handshake control
	assign advance      = !out_valid_q || out_ch.ready;
	assign fire         = valid_s1 && advance;
	assign in_ch.ready  = !valid_s1 || advance;
	assign in_xfer      = in_ch.valid && in_ch.ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.mode       <= in_ch.mode;
			item_s1.data_byte  <= in_ch.data_byte;
			item_s1.line_level <= in_ch.line_level;
		end
	end

	owm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (core_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= core_res;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.drive_low   = res_q.drive_low;
	assign out_ch.busy_res    = res_q.busy_res;
	assign out_ch.done_res    = res_q.done_res;
	assign out_ch.read_data   = res_q.read_data;
	assign out_ch.no_presence = res_q.no_presence;
	assign out_ch.rejected    = res_q.rejected;

endmodule

>>> rtl/core/owm_checker.sv
// Port-level checks on the result channel of the one-wire bus master.
// Bound to one_wire_bus_master; depends on owm_pkg for widths.
module owm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       drive_low,
	input logic                       busy_res,
	input logic                       done_res,
	input logic [owm_pkg::BYTE_W-1:0] read_data,
	input logic                       no_presence,
	input logic                       rejected
);
	import owm_pkg::*;

	// A stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({drive_low, busy_res, done_res, read_data, no_presence, rejected}))
		else $error("result changed while stalled");

	// Completion leaves the bus master idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// An ignored command leaves the running one in place
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res && !done_res)
		else $error("rejected command changed progress");

	// The line is only pulled low inside a command
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_low |-> busy_res)
		else $error("line driven low while idle");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.drive_low   (out_ch.drive_low),
	.busy_res    (out_ch.busy_res),
	.done_res    (out_ch.done_res),
	.read_data   (out_ch.read_data),
	.no_presence (out_ch.no_presence),
	.rejected    (out_ch.rejected)
);

>>> tb/owm_bus_checker.sv
`timescale 1ns / 100ps
// Result checker for the one-wire bus master: follows register writes and command transfers,
// runs its own copy of the slot sequencer and compares every result transfer field by field.
// Depends on owm_pkg and the channel interfaces in owm_channels.
module owm_bus_checker
	import owm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	owm_in_if                    in_ch,
	owm_out_if                   out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fails,
	output int                   pending,
	output logic                 model_busy,
	output int                   checked,
	output int                   completed,
	output int                   rejects
);

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_R_PRE, SEQ_R_LOW, SEQ_R_DELAY, SEQ_R_POLL, SEQ_R_RECOV,
		SEQ_W_LOW, SEQ_W_HOLD, SEQ_W_GAP,
		SEQ_RD_PRE, SEQ_RD_LOW, SEQ_RD_REL, SEQ_RD_HOLD
	} seq_phase_t;

	// predicted sequencer state and register copy
	logic [CFG_W-1:0]      slot_cfg [N_CFG];
	seq_phase_t            seq_ph;
	logic [TIMER_BITS-1:0] slot_timer;
	logic [BIT_CNT_W-1:0]  bits_left;
	logic [BYTE_W-1:0]     shift_reg;
	logic [BYTE_W-1:0]     rx_byte;
	logic                  absent;
	logic                  cmd_done;
	result_t               bus_results_q [$];

	assign model_busy = (seq_ph != SEQ_IDLE);

	// slot length in ticks, clipped to what the timer can hold
	function automatic int slot_len(seq_phase_t p);
		int v;
		case (p)
			SEQ_R_PRE:   v = slot_cfg[CFG_PRE_RELEASE];
			SEQ_R_LOW:   v = slot_cfg[CFG_RESET_LOW];
			SEQ_R_DELAY: v = slot_cfg[CFG_PRESENCE_DELAY];
			SEQ_R_POLL:  v = slot_cfg[CFG_PRESENCE_TIMEOUT];
			SEQ_R_RECOV: v = slot_cfg[CFG_RECOVERY];
			SEQ_W_LOW, SEQ_RD_PRE, SEQ_RD_LOW, SEQ_RD_REL: v = slot_cfg[CFG_SLOT_START];
			SEQ_W_HOLD, SEQ_RD_HOLD: v = slot_cfg[CFG_SLOT_HOLD];
			SEQ_W_GAP:   v = slot_cfg[CFG_BIT_GAP];
			default:     v = 0;
		endcase
		if (v > TIMER_MAX)
			v = TIMER_MAX;
		return v;
	endfunction

	// work done when a slot runs out; gives the slot that follows
	function automatic seq_phase_t end_slot(seq_phase_t p, logic lv);
		case (p)
			SEQ_R_PRE:   return SEQ_R_LOW;
			SEQ_R_LOW:   return SEQ_R_DELAY;
			SEQ_R_DELAY: return SEQ_R_POLL;
			SEQ_R_POLL: begin
				absent = 1'b1;
				return SEQ_R_RECOV;
			end
			SEQ_W_LOW:   return SEQ_W_HOLD;
			SEQ_W_HOLD:  return SEQ_W_GAP;
			SEQ_W_GAP: begin
				shift_reg = shift_reg >> 1;
				if (bits_left != 0)
					bits_left--;
				return (bits_left != 0) ? SEQ_W_LOW : SEQ_IDLE;
			end
			SEQ_RD_PRE:  return SEQ_RD_LOW;
			SEQ_RD_LOW:  return SEQ_RD_REL;
			SEQ_RD_REL: begin
				shift_reg = {lv, shift_reg[BYTE_W-1:1]};
				if (bits_left != 0)
					bits_left--;
				return SEQ_RD_HOLD;
			end
			SEQ_RD_HOLD: begin
				if (bits_left == 0) begin
					rx_byte = shift_reg;
					return SEQ_IDLE;
				end
				return SEQ_RD_LOW;
			end
			default:     return SEQ_IDLE;
		endcase
	endfunction

	// move into a slot, running straight through slots of zero length
	function automatic void enter_slot(seq_phase_t p, logic lv);
		seq_phase_t nxt;
		nxt = p;
		while (nxt != SEQ_IDLE && slot_len(nxt) == 0)
			nxt = end_slot(nxt, lv);
		seq_ph = nxt;
		if (nxt == SEQ_IDLE) begin
			slot_timer = '0;
			cmd_done   = 1'b1;
		end else begin
			slot_timer = TIMER_BITS'(slot_len(nxt));
		end
	endfunction

	// one tick or command through the sequencer copy
	function automatic result_t advance_bus(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] d,
		logic lv);
		result_t r;
		logic    rej;
		rej      = 1'b0;
		cmd_done = 1'b0;
		if (m != MODE_TICK) begin
			if (seq_ph != SEQ_IDLE) begin
				rej = 1'b1;
			end else if (m == MODE_RESET) begin
				enter_slot(SEQ_R_PRE, lv);
			end else if (m == MODE_WRITE) begin
				shift_reg = d;
				bits_left = BIT_CNT_W'(BYTE_W);
				enter_slot(SEQ_W_LOW, lv);
			end else begin
				bits_left = BIT_CNT_W'(BYTE_W);
				enter_slot(SEQ_RD_PRE, lv);
			end
		end else if (seq_ph != SEQ_IDLE) begin
			if (seq_ph == SEQ_R_POLL && !lv) begin
				// presence pulse ends polling early
				absent = 1'b0;
				enter_slot(SEQ_R_RECOV, lv);
			end else begin
				if (slot_timer != 0)
					slot_timer--;
				if (slot_timer == 0)
					enter_slot(end_slot(seq_ph, lv), lv);
			end
		end
		r.drive_low   = (seq_ph == SEQ_R_LOW) || (seq_ph == SEQ_W_LOW) ||
			(seq_ph == SEQ_RD_LOW) || (seq_ph == SEQ_W_HOLD && !shift_reg[0]);
		r.busy_res    = (seq_ph != SEQ_IDLE);
		r.done_res    = cmd_done;
		r.read_data   = rx_byte;
		r.no_presence = absent;
		r.rejected    = rej;
		return r;
	endfunction

	function automatic void check_field(string field, int want, int got);
		if (want != got) begin
			fails++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endfunction

	// follow writes and transfers; predict on input, compare on output
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < N_CFG; i++)
				slot_cfg[i] = CFG_RESET[i];
			seq_ph     = SEQ_IDLE;
			slot_timer = '0;
			bits_left  = '0;
			shift_reg  = '0;
			rx_byte    = '0;
			absent     = 1'b0;
			cmd_done   = 1'b0;
			bus_results_q.delete();
			fails      = 0;
			pending    = 0;
			checked    = 0;
			completed  = 0;
			rejects    = 0;
		end else begin
			if (cfg_we && cfg_index < N_CFG)
				slot_cfg[cfg_index] = cfg_data;
			if (in_ch.valid && in_ch.ready) begin
				want = advance_bus(in_ch.mode, in_ch.data_byte, in_ch.line_level);
				if (want.done_res)
					completed++;
				if (want.rejected)
					rejects++;
				bus_results_q.push_back(want);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (bus_results_q.size() == 0) begin
					fails++;
					$display("%0t ns: result transfer with nothing expected, actual %h", $time,
						{out_ch.drive_low, out_ch.busy_res, out_ch.done_res, out_ch.read_data,
						out_ch.no_presence, out_ch.rejected});
				end else begin
					want = bus_results_q.pop_front();
					checked++;
					check_field("drive_low", want.drive_low, out_ch.drive_low);
					check_field("busy_res", want.busy_res, out_ch.busy_res);
					check_field("done_res", want.done_res, out_ch.done_res);
					check_field("read_data", want.read_data, out_ch.read_data);
					check_field("no_presence", want.no_presence, out_ch.no_presence);
					check_field("rejected", want.rejected, out_ch.rejected);
				end
			end
			pending = bus_results_q.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the one-wire bus master testbench: clock, reset, register settings and command stimulus.
// Depends on owm_pkg, owm_channels, the block itself and owm_bus_checker.
module tb_top;
	import owm_pkg::*;

	localparam int IDLE_LIMIT        = 500;
	localparam int SETTLE_CYCLES     = 8;
	localparam int RAND_SETTINGS     = 5;
	localparam int ITEMS_PER_SETTING = 60;
	localparam int LONG_SLOT         = 520;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fails;
	int                   pending;
	int                   checked;
	int                   completed;
	int                   rejects;
	logic                 model_busy;
	int                   sent;
	int                   settings;
	int                   quiet;
	bit                   src_gaps;
	bit                   sink_stalls;
	logic [CFG_W-1:0]     cfg_plan [N_CFG];

	owm_in_if  in_ch ();
	owm_out_if out_ch ();

	one_wire_bus_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	owm_bus_checker bus_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fails      (fails),
		.pending    (pending),
		.model_busy (model_busy),
		.checked    (checked),
		.completed  (completed),
		.rejects    (rejects)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// one command or tick transfer; called and returns at a falling edge
	task automatic send_item(mode_t m, logic [BYTE_W-1:0] d, logic lv);
		int gap;
		gap = src_gaps ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.mode       <= m;
		in_ch.data_byte  <= d;
		in_ch.line_level <= lv;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
		@(negedge clk);
	endtask

	// ticks until the command in flight completes; line pulled low about one tick in one_in
	task automatic tick_until_idle(int one_in, bit noisy);
		while (model_busy) begin
			if (noisy && $urandom_range(0, 19) == 0)
				send_item(mode_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
			else
				send_item(MODE_TICK, 8'($urandom), ($urandom_range(1, one_in) != 1));
		end
	endtask

	task automatic plan_all(int lo, int hi);
		for (int i = 0; i < N_CFG; i++)
			cfg_plan[i] = CFG_W'($urandom_range(lo, hi));
	endtask

	// back-to-back register writes from cfg_plan
	task automatic load_cfg();
		for (int i = 0; i < N_CFG; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= cfg_plan[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		settings++;
	endtask

	// input goes idle, all results in, then a settling wait for the pipeline to empty
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// result side: random stall before each transfer, with stall-free stretches
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_stalls ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			if ($urandom_range(0, 63) == 0)
				sink_stalls = !sink_stalls;
			@(negedge clk);
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet <= 0;
			end else if (quiet + 1 >= IDLE_LIMIT) begin
				$display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("one_wire_bus_master test failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		int base;
		in_ch.valid      = 1'b0;
		in_ch.mode       = MODE_TICK;
		in_ch.data_byte  = '0;
		in_ch.line_level = 1'b1;
		cfg_we           = 1'b0;
		cfg_index        = CFG_PRE_RELEASE;
		cfg_data         = '0;
		sent             = 0;
		settings         = 0;
		quiet            = 0;
		src_gaps         = 1'b1;
		sink_stalls      = 1'b1;
		arst_n           = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// all slots zero: every command finishes on its own transfer
		plan_all(0, 0);
		load_cfg();
		send_item(MODE_TICK, 8'hA5, 1'b0);
		send_item(MODE_RESET, 8'h00, 1'b1);
		send_item(MODE_WRITE, 8'h00, 1'b1);
		send_item(MODE_WRITE, 8'hFF, 1'b0);
		send_item(MODE_READ, 8'h00, 1'b1);
		send_item(MODE_READ, 8'hFF, 1'b0);
		settle();

		// one-tick slots: commands while busy, presence seen while polling
		plan_all(1, 1);
		load_cfg();
		send_item(MODE_RESET, 8'h00, 1'b1);
		send_item(MODE_WRITE, 8'h5A, 1'b1);
		send_item(MODE_READ, 8'h00, 1'b0);
		repeat (3) send_item(MODE_TICK, 8'h00, 1'b1);
		send_item(MODE_TICK, 8'h00, 1'b0);
		tick_until_idle(2, 1'b0);
		settle();

		// long presence timeout using the top timer bit, polling mostly runs out
		plan_all(0, 1);
		cfg_plan[CFG_PRESENCE_TIMEOUT] = CFG_W'(LONG_SLOT);
		load_cfg();
		src_gaps = 1'b0;
		send_item(MODE_RESET, 8'h00, 1'b1);
		send_item(MODE_READ, 8'hFF, 1'b1);
		tick_until_idle(4000, 1'b0);
		settle();

		// random settings, mostly complete command sequences with some noise
		for (int s = 0; s < RAND_SETTINGS; s++) begin
			if (s % 3 == 2)
				plan_all(0, 12);
			else
				plan_all(0, 3);
			src_gaps = ($urandom_range(0, 3) != 0);
			load_cfg();
			base = sent;
			while (sent - base < ITEMS_PER_SETTING) begin
				if ($urandom_range(0, 5) == 0) begin
					send_item(mode_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
				end else begin
					send_item(mode_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
					tick_until_idle(2, 1'b1);
				end
			end
			tick_until_idle(2, 1'b0);
			settle();
		end

		$display("run covered %0d input transfers under %0d register settings", sent, settings);
		$display("%0d results compared, %0d commands completed, %0d rejected while busy",
			checked, completed, rejects);
		if (fails == 0 && pending == 0)
			$display("one_wire_bus_master test passed");
		else
			$display("one_wire_bus_master test failed");
		$finish;
	end

endmodule
